// ----- rtl/bxavg_pkg.sv -----
// ----------------------------------------------------------------------------
// bxavg_pkg
// Shared constants and types for the box average downscaler.
// ----------------------------------------------------------------------------
package bxavg_pkg;

	// Fixed field and register widths
	localparam int DIM_BITS      = 13;  // width/height registers, up to 4096
	localparam int POS_BITS      = 12;  // column and row position counters
	localparam int SUM_BITS      = 24;  // block sum accumulators
	localparam int AVG_BITS      = 16;  // output sample
	localparam int BS_REG_BITS   = 5;   // block size register
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 13;
	localparam int MAX_DIM       = 4096;

	// Register reset values
	localparam logic [DIM_BITS-1:0]    WIDTH_RST  = 13'd640;
	localparam logic [DIM_BITS-1:0]    HEIGHT_RST = 13'd480;
	localparam logic [BS_REG_BITS-1:0] BLOCK_RST  = 5'd2;

	// Parameter defaults
	localparam int MAX_OUT_COLS_DEF = 256;
	localparam int PIXEL_BITS_DEF   = 16;
	localparam int MAX_BLOCK_DEF    = 16;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_BLOCK_SIZE   = 2'd2
	} cfg_reg_t;

	// Per-item classification handed from front to back
	typedef struct packed {
		logic first;  // first sample of its block: overwrite accumulator
		logic emit;   // last sample of its block: produce an average
		logic flast;  // block is the final one of the frame
	} blk_flags_t;

endpackage

// ----- rtl/bxavg_queue.sv -----
// ----------------------------------------------------------------------------
// bxavg_queue
// Small register FIFO that decouples the classifier from the accumulator.
// ----------------------------------------------------------------------------
module bxavg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic [WIDTH-1:0]                   push_data,
	input  logic                               pop,
	output logic [WIDTH-1:0]                   head_data,
	output logic [$clog2(DEPTH + 1)-1:0]       count
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    store_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign head_data = store_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/bxavg_front.sv -----
// ----------------------------------------------------------------------------
// bxavg_front
// Accepts samples, tracks raster position, finds the block of each sample
// and classifies it before handing it to the queue.
// ----------------------------------------------------------------------------
module bxavg_front #(
	parameter int MAX_OUT_COLS = bxavg_pkg::MAX_OUT_COLS_DEF,
	parameter int PIXEL_BITS   = bxavg_pkg::PIXEL_BITS_DEF,
	parameter int MAX_BLOCK    = bxavg_pkg::MAX_BLOCK_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [PIXEL_BITS-1:0]                  pixel,
	input  logic                                   frame_start,
	input  logic [bxavg_pkg::DIM_BITS-1:0]         w_eff,
	input  logic [bxavg_pkg::DIM_BITS-1:0]         h_eff,
	input  logic [$clog2(MAX_BLOCK + 1)-1:0]       bs_eff,
	input  logic [bxavg_pkg::QCNT_BITS-1:0]        q_count,
	output logic                                   push,
	output logic [PIXEL_BITS-1:0]                  push_pix,
	output logic [((MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1)-1:0] push_bcol,
	output logic [$clog2(MAX_BLOCK + 1)-1:0]       push_bs,
	output bxavg_pkg::blk_flags_t                  push_flags
);
	import bxavg_pkg::*;

	localparam int BS_BITS  = $clog2(MAX_BLOCK + 1);
	localparam int XB       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CW       = (XB + 1 > BS_BITS) ? XB + 1 : BS_BITS;
	localparam int COL_BITS = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
	localparam int K        = DIM_BITS + XB;
	localparam int RW       = K + 1;
	localparam int PW       = DIM_BITS + RW;
	localparam int TAB_N    = 2 ** BS_BITS;
	localparam int SW       = QCNT_BITS + 1;

	// Reciprocal table: ceil(2^K / d), exact quotient for 13-bit numerators
	logic [RW-1:0] rtab [TAB_N];
	for (genvar d = 0; d < TAB_N; d++) begin : g_rtab
		localparam longint unsigned DV = (d == 0) ? 1 : d;
		localparam longint unsigned RV = ((64'd1 << K) + DV - 1) / DV;
		assign rtab[d] = RW'(RV);
	end

	logic                accept;
	logic [POS_BITS-1:0] col_q, row_q, col_cur, row_cur, col_nxt, row_nxt;
	logic [XB-1:0]       xb_q, yb_q, x_cur, y_cur, x_nxt, y_nxt;
	logic [CW-1:0]       x_inc, y_inc;

	// Stage 1
	logic                v_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [POS_BITS-1:0] col_s1, row_s1;
	logic [XB-1:0]       x_s1, y_s1;
	logic [BS_BITS-1:0]  bs_s1;
	logic [DIM_BITS-1:0] w_s1, h_s1;

	// Stage 2
	logic                v_s2;
	logic [PIXEL_BITS-1:0] pix_s2;
	logic [POS_BITS-1:0] bcol_s2, brow_s2;
	logic [DIM_BITS-1:0] oc_s2, orow_s2;
	logic [XB-1:0]       x_s2, y_s2;
	logic [BS_BITS-1:0]  bs_s2;

	logic [PW-1:0]       p_col, p_row, p_oc, p_orow;
	logic [DIM_BITS-1:0] oc_lim, bcol_x, brow_x, bs_m1;
	logic                in_area;

	assign accept   = in_valid && !in_stall;
	// Hold off input while the queue plus the two stages in flight could overflow
	assign in_stall = (SW'(q_count) + SW'(v_s1) + SW'(v_s2)) >= SW'(QUEUE_DEPTH);

	always_comb begin
		col_cur = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		x_cur   = frame_start ? '0 : xb_q;
		y_cur   = frame_start ? '0 : yb_q;
		x_inc   = CW'(x_cur) + CW'(1);
		y_inc   = CW'(y_cur) + CW'(1);
		x_nxt   = (x_inc >= CW'(bs_eff)) ? '0 : x_cur + XB'(1);
		y_nxt   = y_cur;
		col_nxt = col_cur + POS_BITS'(1);
		row_nxt = row_cur;
		if (DIM_BITS'(col_cur) + DIM_BITS'(1) >= w_eff) begin
			col_nxt = '0;
			x_nxt   = '0;
			y_nxt   = (y_inc >= CW'(bs_eff)) ? '0 : y_cur + XB'(1);
			if (DIM_BITS'(row_cur) + DIM_BITS'(1) >= h_eff) begin
				row_nxt = '0;
				y_nxt   = '0;
			end else begin
				row_nxt = row_cur + POS_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			xb_q  <= '0;
			yb_q  <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
				xb_q  <= x_nxt;
				yb_q  <= y_nxt;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Block coordinates and block counts by reciprocal multiply
	always_comb begin
		p_col  = PW'(col_s1) * PW'(rtab[bs_s1]);
		p_row  = PW'(row_s1) * PW'(rtab[bs_s1]);
		p_oc   = PW'(w_s1) * PW'(rtab[bs_s1]);
		p_orow = PW'(h_s1) * PW'(rtab[bs_s1]);
	end

	always_ff @(posedge clk) begin
		pix_s1  <= pixel;
		col_s1  <= col_cur;
		row_s1  <= row_cur;
		x_s1    <= x_cur;
		y_s1    <= y_cur;
		bs_s1   <= bs_eff;
		w_s1    <= w_eff;
		h_s1    <= h_eff;
		pix_s2  <= pix_s1;
		bcol_s2 <= p_col[K +: POS_BITS];
		brow_s2 <= p_row[K +: POS_BITS];
		oc_s2   <= p_oc[K +: DIM_BITS];
		orow_s2 <= p_orow[K +: DIM_BITS];
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		bs_s2   <= bs_s1;
	end

	// Classify: drop samples of partial edge blocks and excess columns
	always_comb begin
		oc_lim  = (oc_s2 > DIM_BITS'(MAX_OUT_COLS)) ? DIM_BITS'(MAX_OUT_COLS) : oc_s2;
		bcol_x  = DIM_BITS'(bcol_s2);
		brow_x  = DIM_BITS'(brow_s2);
		bs_m1   = DIM_BITS'(bs_s2) - DIM_BITS'(1);
		in_area = (bcol_x < oc_lim) && (brow_x < orow_s2);
		push_flags.first = (x_s2 == '0) && (y_s2 == '0);
		push_flags.emit  = (DIM_BITS'(x_s2) == bs_m1) && (DIM_BITS'(y_s2) == bs_m1);
		push_flags.flast = (bcol_x + DIM_BITS'(1) == oc_lim) &&
		                   (brow_x + DIM_BITS'(1) == orow_s2);
	end

	assign push      = v_s2 && in_area;
	assign push_pix  = pix_s2;
	assign push_bcol = bcol_s2[COL_BITS-1:0];
	assign push_bs   = bs_s2;

endmodule

// ----- rtl/bxavg_back.sv -----
// ----------------------------------------------------------------------------
// bxavg_back
// Accumulates samples into the column sum memory and divides each finished
// block sum by the block area.
// ----------------------------------------------------------------------------
module bxavg_back #(
	parameter int MAX_OUT_COLS = bxavg_pkg::MAX_OUT_COLS_DEF,
	parameter int PIXEL_BITS   = bxavg_pkg::PIXEL_BITS_DEF,
	parameter int MAX_BLOCK    = bxavg_pkg::MAX_BLOCK_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   head_valid,
	input  logic [PIXEL_BITS-1:0]                  head_pix,
	input  logic [((MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1)-1:0] head_bcol,
	input  logic [$clog2(MAX_BLOCK + 1)-1:0]       head_bs,
	input  bxavg_pkg::blk_flags_t                  head_flags,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [bxavg_pkg::AVG_BITS-1:0]         avg_pixel,
	output logic                                   frame_last
);
	import bxavg_pkg::*;

	localparam int BS_BITS  = $clog2(MAX_BLOCK + 1);
	localparam int XB       = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int COL_BITS = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
	localparam int K        = SUM_BITS + XB;
	localparam int RW       = K + 1;
	localparam int PW       = SUM_BITS + RW;
	localparam int TAB_N    = 2 ** BS_BITS;

	// Reciprocal table: ceil(2^K / d), exact quotient for 24-bit numerators
	logic [RW-1:0] rtab [TAB_N];
	for (genvar d = 0; d < TAB_N; d++) begin : g_rtab
		localparam longint unsigned DV = (d == 0) ? 1 : d;
		localparam longint unsigned RV = ((64'd1 << K) + DV - 1) / DV;
		assign rtab[d] = RW'(RV);
	end

	logic                  en;
	logic [SUM_BITS-1:0]   sums_mem [MAX_OUT_COLS];
	logic [MAX_OUT_COLS-1:0] written_q;

	// Stage 1: read data arrives, sum is formed and written back
	logic                  v_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [COL_BITS-1:0]   bcol_s1;
	logic [BS_BITS-1:0]    bs_s1;
	blk_flags_t            flags_s1;
	logic [SUM_BITS-1:0]   rd_s1;
	logic                  rv_s1;
	logic [SUM_BITS-1:0]   base_s1, sum_s1;

	// Stage 2: first division by the block side
	logic                  v_s2;
	logic [SUM_BITS-1:0]   sum_s2;
	logic [COL_BITS-1:0]   bcol_s2;
	logic [BS_BITS-1:0]    bs_s2;
	logic                  emit_s2, flast_s2;
	logic [PW-1:0]         prod_s2;

	// Stage 3: second division by the block side
	logic                  v_s3;
	logic [SUM_BITS-1:0]   q1_s3;
	logic [BS_BITS-1:0]    bs_s3;
	logic                  flast_s3;
	logic [PW-1:0]         prod_s3;

	logic                  out_valid_q;
	logic [AVG_BITS-1:0]   avg_q;
	logic                  flast_q;

	// Whole back end advances together unless the result register is held
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && head_valid;

	always_comb begin
		if (flags_s1.first) begin
			base_s1 = '0;
		end else if (v_s2 && (bcol_s2 == bcol_s1)) begin
			base_s1 = sum_s2;
		end else if (rv_s1) begin
			base_s1 = rd_s1;
		end else begin
			base_s1 = '0;
		end
		sum_s1 = base_s1 + SUM_BITS'(pix_s1);
	end

	// floor(floor(s / b) / b) equals floor(s / b^2)
	assign prod_s2 = PW'(sum_s2) * PW'(rtab[bs_s2]);
	assign prod_s3 = PW'(q1_s3) * PW'(rtab[bs_s3]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1) begin
				sums_mem[bcol_s1] <= sum_s1;
			end
			rd_s1 <= sums_mem[head_bcol];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (v_s1) begin
				written_q[bcol_s1] <= 1'b1;
			end
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && emit_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv_s1    <= written_q[head_bcol];
			pix_s1   <= head_pix;
			bcol_s1  <= head_bcol;
			bs_s1    <= head_bs;
			flags_s1 <= head_flags;
			sum_s2   <= sum_s1;
			bcol_s2  <= bcol_s1;
			bs_s2    <= bs_s1;
			emit_s2  <= flags_s1.emit;
			flast_s2 <= flags_s1.flast;
			q1_s3    <= prod_s2[K +: SUM_BITS];
			bs_s3    <= bs_s2;
			flast_s3 <= flast_s2;
			avg_q    <= prod_s3[K +: AVG_BITS];
			flast_q  <= flast_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign avg_pixel  = avg_q;
	assign frame_last = flast_q;

endmodule

// ----- rtl/box_average_downscaler_top.sv -----
// ----------------------------------------------------------------------------
// box_average_downscaler_top
// Box filter downscaler: averages each square block of a raster image.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the input channel (in_valid / in_stall, pixel,
//   frame_start) in raster order, one item per cycle while in_stall is low. Raise
//   frame_start on the first sample of a frame to restart the position
//   counters. Each whole block of block_size x block_size samples yields
//   one item on the output channel (out_valid / out_stall, avg_pixel,
//   frame_last): the block sum divided by the block area, truncated.
//   frame_last marks the final block of the frame. Partial edge blocks
//   and block columns beyond MAX_OUT_COLS produce nothing.
//   Path: after the block's last sample is accepted, the average passes
//   two classify stages, the queue, read/accumulate, two reciprocal-multiply
//   divide stages and the result register. Throughput: one sample per cycle
//   while out_stall holds no result, set by the column sum memory, which reads
//   one entry and writes one entry per cycle, with write-back forwarding.
//   While out_stall holds a result, the back end freezes and the 4-entry
//   queue absorbs samples; in_stall rises once the queue plus the two
//   classify stages could fill it.
//   Reset: counters clear, registers take 640 x 480 with 2 x 2 blocks, and
//   column sums read as zero until written; no clearing pass is needed.
//   Write configuration only between items, over cfg_wr_en/cfg_addr/cfg_wdata.
// ----------------------------------------------------------------------------
module box_average_downscaler_top #(
	parameter int MAX_OUT_COLS = bxavg_pkg::MAX_OUT_COLS_DEF,
	parameter int PIXEL_BITS   = bxavg_pkg::PIXEL_BITS_DEF,
	parameter int MAX_BLOCK    = bxavg_pkg::MAX_BLOCK_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bxavg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [bxavg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [PIXEL_BITS-1:0]                pixel,
	input  logic                                 frame_start,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [bxavg_pkg::AVG_BITS-1:0]       avg_pixel,
	output logic                                 frame_last
);
	import bxavg_pkg::*;

	localparam int BS_BITS  = $clog2(MAX_BLOCK + 1);
	localparam int COL_BITS = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
	localparam int FLAG_W   = $bits(blk_flags_t);
	localparam int ENTRY_W  = PIXEL_BITS + COL_BITS + BS_BITS + FLAG_W;

	// Configuration registers
	logic [DIM_BITS-1:0]    width_q;
	logic [DIM_BITS-1:0]    height_q;
	logic [BS_REG_BITS-1:0] block_q;

	// Clamped working values
	logic [DIM_BITS-1:0]    w_eff, h_eff;
	logic [BS_BITS-1:0]     bs_eff;

	// Front to queue
	logic                   q_push;
	logic [PIXEL_BITS-1:0]  push_pix;
	logic [COL_BITS-1:0]    push_bcol;
	logic [BS_BITS-1:0]     push_bs;
	blk_flags_t             push_flags;

	// Queue to back
	logic [ENTRY_W-1:0]     head_data;
	logic [QCNT_BITS-1:0]   q_count;
	logic                   q_pop;
	logic [PIXEL_BITS-1:0]  head_pix;
	logic [COL_BITS-1:0]    head_bcol;
	logic [BS_BITS-1:0]     head_bs;
	blk_flags_t             head_flags;

	// Take register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			block_q  <= BLOCK_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata[DIM_BITS-1:0];
				end
				CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[DIM_BITS-1:0];
				end
				CFG_BLOCK_SIZE: begin
					block_q <= cfg_wdata[BS_REG_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Zero counts as one, oversize values saturate
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_BITS'(1);
		end else if (width_q > DIM_BITS'(MAX_DIM)) begin
			w_eff = DIM_BITS'(MAX_DIM);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_BITS'(1);
		end else if (height_q > DIM_BITS'(MAX_DIM)) begin
			h_eff = DIM_BITS'(MAX_DIM);
		end else begin
			h_eff = height_q;
		end
		if (block_q == '0) begin
			bs_eff = BS_BITS'(1);
		end else if (int'(block_q) > MAX_BLOCK) begin
			bs_eff = BS_BITS'(MAX_BLOCK);
		end else begin
			bs_eff = BS_BITS'(block_q);
		end
	end

	bxavg_front #(
		.MAX_OUT_COLS (MAX_OUT_COLS),
		.PIXEL_BITS   (PIXEL_BITS),
		.MAX_BLOCK    (MAX_BLOCK)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.frame_start (frame_start),
		.w_eff       (w_eff),
		.h_eff       (h_eff),
		.bs_eff      (bs_eff),
		.q_count     (q_count),
		.push        (q_push),
		.push_pix    (push_pix),
		.push_bcol   (push_bcol),
		.push_bs     (push_bs),
		.push_flags  (push_flags)
	);

	bxavg_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_flags, push_bs, push_bcol, push_pix}),
		.pop       (q_pop),
		.head_data (head_data),
		.count     (q_count)
	);

	assign {head_flags, head_bs, head_bcol, head_pix} = head_data;

	bxavg_back #(
		.MAX_OUT_COLS (MAX_OUT_COLS),
		.PIXEL_BITS   (PIXEL_BITS),
		.MAX_BLOCK    (MAX_BLOCK)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_count != '0),
		.head_pix   (head_pix),
		.head_bcol  (head_bcol),
		.head_bs    (head_bs),
		.head_flags (head_flags),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.avg_pixel  (avg_pixel),
		.frame_last (frame_last)
	);

`ifndef SYNTH
	// Credit check must keep the queue from overflowing
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count != QCNT_BITS'(QUEUE_DEPTH)) || q_pop)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_count != '0))
		else $error("queue pop while empty");

	// Back end must stay frozen while a result is held
	a_freeze_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !q_pop)
		else $error("queue popped while output held");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ----- sim/box_average_downscaler_checker.sv -----
// ----------------------------------------------------------------------------
// box_average_downscaler_checker
// Watches both channels and the register port of the box average downscaler,
// predicts every block average from the accepted samples and compares the
// averages that the block hands out, in order, field by field.
// ----------------------------------------------------------------------------
module box_average_downscaler_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bxavg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [bxavg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [bxavg_pkg::PIXEL_BITS_DEF-1:0] pixel,
	input  logic                                 frame_start,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [bxavg_pkg::AVG_BITS-1:0]       avg_pixel,
	input  logic                                 frame_last,
	output int                                   fail_count,
	output int                                   waiting,
	output int                                   samples_seen,
	output int                                   blocks_seen
);
	import bxavg_pkg::*;

	localparam int OUT_COLS = MAX_OUT_COLS_DEF;
	localparam int MAX_BS   = MAX_BLOCK_DEF;

	typedef struct packed {
		logic [AVG_BITS-1:0] avg;
		logic                flast;
	} block_avg_t;

	logic [DIM_BITS-1:0]    width_reg;
	logic [DIM_BITS-1:0]    height_reg;
	logic [BS_REG_BITS-1:0] bsize_reg;
	logic [SUM_BITS-1:0]    col_sum [OUT_COLS];
	logic [POS_BITS-1:0]    col_pos;
	logic [POS_BITS-1:0]    row_pos;
	logic [3:0]             bx;
	logic [3:0]             by;
	block_avg_t             avg_fifo [$];

	function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Fold one sample into the column sums; queue an average on a block's last sample.
	task automatic take_sample(input logic [PIXEL_BITS_DEF-1:0] pix, input logic fs);
		int unsigned bs, w, h, cols, rows, bcol, brow;
		block_avg_t  res;
		bs = clamp_to(bsize_reg, MAX_BS);
		w = clamp_to(width_reg, MAX_DIM);
		h = clamp_to(height_reg, MAX_DIM);
		cols = w / bs;
		rows = h / bs;
		if (cols > OUT_COLS)
			cols = OUT_COLS;
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
			bx = '0;
			by = '0;
		end
		bcol = col_pos / bs;
		brow = row_pos / bs;
		if (bcol < cols && brow < rows) begin
			if (bx == 0 && by == 0)
				col_sum[bcol] = SUM_BITS'(pix);
			else
				col_sum[bcol] = col_sum[bcol] + SUM_BITS'(pix);
			if (bx == bs - 1 && by == bs - 1) begin
				res.avg = AVG_BITS'(col_sum[bcol] / (bs * bs));
				res.flast = (bcol == cols - 1) && (brow == rows - 1);
				avg_fifo.push_back(res);
			end
		end
		if (bx + 1 >= bs)
			bx = '0;
		else
			bx = bx + 1'b1;
		if (col_pos + 1 >= w) begin
			col_pos = '0;
			bx = '0;
			if (by + 1 >= bs)
				by = '0;
			else
				by = by + 1'b1;
			if (row_pos + 1 >= h) begin
				row_pos = '0;
				by = '0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		block_avg_t want;
		if (!arst_n) begin
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			bsize_reg = BLOCK_RST;
			for (int i = 0; i < OUT_COLS; i++)
				col_sum[i] = '0;
			col_pos = '0;
			row_pos = '0;
			bx = '0;
			by = '0;
			avg_fifo.delete();
			fail_count = 0;
			samples_seen = 0;
			blocks_seen = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_addr))
					CFG_IMAGE_WIDTH:  width_reg = cfg_wdata[DIM_BITS-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_wdata[DIM_BITS-1:0];
					CFG_BLOCK_SIZE:   bsize_reg = cfg_wdata[BS_REG_BITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				samples_seen++;
				take_sample(pixel, frame_start);
			end
			if (out_valid && !out_stall) begin
				blocks_seen++;
				if (avg_fifo.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected average: expected none,", $time,
						" got avg_pixel %0d frame_last %0b", avg_pixel, frame_last);
				end else begin
					want = avg_fifo.pop_front();
					if (avg_pixel !== want.avg) begin
						fail_count++;
						$display("%0t: avg_pixel mismatch: expected %0d, got %0d",
							$time, want.avg, avg_pixel);
					end
					if (frame_last !== want.flast) begin
						fail_count++;
						$display("%0t: frame_last mismatch: expected %0b, got %0b",
							$time, want.flast, frame_last);
					end
				end
			end
		end
		waiting = avg_fifo.size();
	end

endmodule

// ----- sim/tb_box_average_downscaler_top.sv -----
// ----------------------------------------------------------------------------
// tb_box_average_downscaler_top
// Drives raster samples and register settings into the box average downscaler.
// A directed opening covers extreme samples, tiny images and frame restarts;
// random phases then sweep block sizes, image shapes and clamped register
// values under bursty input and random output stalls. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_box_average_downscaler_top;
	import bxavg_pkg::*;

	localparam int PIX_BITS = PIXEL_BITS_DEF;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic [PIX_BITS-1:0]      pixel;
	logic                     frame_start;
	logic                     out_valid;
	logic                     out_stall;
	logic [AVG_BITS-1:0]      avg_pixel;
	logic                     frame_last;

	int fail_count;
	int waiting;
	int samples_seen;
	int blocks_seen;

	int burst_left;
	int settings_used;
	int random_items;

	always #2 clk = ~clk;

	box_average_downscaler_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.avg_pixel   (avg_pixel),
		.frame_last  (frame_last)
	);

	box_average_downscaler_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.avg_pixel    (avg_pixel),
		.frame_last   (frame_last),
		.fail_count   (fail_count),
		.waiting      (waiting),
		.samples_seen (samples_seen),
		.blocks_seen  (blocks_seen)
	);

	// Receiver: switch between free flow, light and heavy stalling in runs of
	// random length so that stalls land on every pipeline phase.
	initial begin
		int mode;
		int run_len;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			run_len = $urandom_range(40, 300);
			repeat (run_len) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	// Bias samples toward the extremes; otherwise take any 16-bit value.
	function automatic logic [PIX_BITS-1:0] rand_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return PIX_BITS'($urandom);
	endfunction

	// Offer one item and hold it until accepted. Between bursts drop valid
	// for a random gap; now and then run a long burst with no gaps at all.
	task automatic send_sample(input logic [PIX_BITS-1:0] pix, input logic fs);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 48);
		end
		in_valid <= 1'b1;
		pixel <= pix;
		frame_start <= fs;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	// Hold the input until every expected average is out, then let samples
	// that produce nothing drain through the pipeline.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Write all three registers on consecutive cycles; the block size write
	// carries random upper bits that the register must ignore.
	task automatic write_regs(input int w, input int h, input int bs);
		cfg_wr_en <= 1'b1;
		cfg_addr <= CFG_IMAGE_WIDTH;
		cfg_wdata <= CFG_DATA_BITS'(w);
		@(negedge clk);
		cfg_addr <= CFG_IMAGE_HEIGHT;
		cfg_wdata <= CFG_DATA_BITS'(h);
		@(negedge clk);
		cfg_addr <= CFG_BLOCK_SIZE;
		cfg_wdata <= {CFG_DATA_BITS'($urandom_range(0, 255)) << BS_REG_BITS}
			| CFG_DATA_BITS'(bs);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Send n random samples, marking a frame start every frame_len items when asked,
	// plus a rare stray frame start anywhere.
	task automatic send_run(input int n, input int frame_len, input bit with_starts);
		logic fs;
		for (int i = 0; i < n; i++) begin
			fs = (with_starts && (i % frame_len == 0)) || ($urandom_range(0, 99) == 0);
			send_sample(rand_pixel(), fs);
		end
	endtask

	// Pick a register setting for one random phase and push one or two frames through.
	task automatic random_phase();
		int bs_reg, bs, w, h, frame_len, frames, n, r;
		r = $urandom_range(0, 19);
		if (r == 0)
			bs_reg = 0;
		else if (r == 1)
			bs_reg = $urandom_range(17, 31);
		else if (r == 2)
			bs_reg = $urandom_range(5, 16);
		else
			bs_reg = $urandom_range(1, 4);
		bs = (bs_reg == 0) ? 1 : (bs_reg > MAX_BLOCK_DEF ? MAX_BLOCK_DEF : bs_reg);
		if (bs > 4) begin
			w = bs + $urandom_range(0, 2);
			h = bs;
			frames = 1;
		end else begin
			w = bs * $urandom_range(1, 4) + $urandom_range(0, bs - 1);
			h = bs * $urandom_range(1, 2) + $urandom_range(0, bs - 1);
			frames = $urandom_range(1, 2);
		end
		frame_len = w * h;
		n = frames * frame_len;
		// Cut some phases mid-frame so the next setting starts from a stale position.
		if ($urandom_range(0, 4) == 0)
			n = $urandom_range(1, n);
		wait_for_idle();
		write_regs(w, h, bs_reg);
		send_run(n, frame_len, $urandom_range(0, 3) != 0);
		random_items += n;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = CFG_IMAGE_WIDTH;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		burst_left = 0;
		settings_used = 0;
		random_items = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting is 640 x 480: a couple of samples must produce nothing.
		send_sample('1, 1'b1);
		send_sample('0, 1'b0);

		// Two 2x2 blocks: full-scale block, then a block whose sum truncates to zero.
		wait_for_idle();
		write_regs(4, 2, 2);
		send_sample('1, 1'b1);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
		send_sample(16'd3, 1'b0);
		send_sample('1, 1'b0);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);

		// 1x1 image with 1x1 blocks: every sample is a whole frame.
		wait_for_idle();
		write_regs(1, 1, 1);
		send_sample('0, 1'b1);
		send_sample('1, 1'b0);

		// Image smaller than one block: nothing comes out.
		wait_for_idle();
		write_regs(3, 2, 4);
		send_run(6, 6, 1'b1);

		// Restart the frame in the middle of a block.
		wait_for_idle();
		write_regs(2, 2, 2);
		send_sample(16'd100, 1'b1);
		send_sample(16'd200, 1'b0);
		send_sample(16'd300, 1'b0);
		send_sample(16'd7, 1'b1);
		send_sample(16'd9, 1'b0);
		send_sample(16'd11, 1'b0);
		send_sample(16'd13, 1'b0);

		// Zero block size counts as one.
		wait_for_idle();
		write_regs(5, 1, 0);
		send_run(6, 5, 1'b1);

		// Zero height and zero width count as one.
		wait_for_idle();
		write_regs(3, 0, 1);
		send_run(9, 9, 1'b1);
		wait_for_idle();
		write_regs(0, 2, 1);
		send_run(6, 2, 1'b1);

		// All-ones width and height clamp to 4096; 1x1 blocks beyond the
		// column cap are dropped.
		wait_for_idle();
		write_regs(8191, 8191, 1);
		send_run(260, 260, 1'b1);

		while (random_items < 150)
			random_phase();

		// Finish with the largest meaningful sizes written exactly.
		wait_for_idle();
		write_regs(4096, 4096, 16);
		send_run(16, 16, 1'b1);

		wait_for_idle();
		repeat (30) @(negedge clk);

		$display("Checked %0d block averages from %0d samples over %0d register settings.",
			blocks_seen, samples_seen, settings_used);
		$display("Covered mixed block sizes, clamped registers, the column cap, edge drops and frame restarts.");
		if (fail_count == 0 && waiting == 0) begin
			$display("** box_average_downscaler_top: PASSED **");
		end else begin
			$display("** box_average_downscaler_top: FAILED **");
		end
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#4000000;
		$display("Timeout with %0d averages still expected.", waiting);
		$display("** box_average_downscaler_top: FAILED **");
		$finish;
	end

endmodule
